[src/pet_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pet_pkg
// Shared types, register indexes and the arctangent table for the pose error
// pipeline.
// ----------------------------------------------------------------------------
package pet_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_ENTRIES      = 24;
  localparam int CFG_IDX_W         = 3;
  localparam int CFG_DATA_W        = 19;
  localparam int DIST_MAX          = 524287;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_X       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_Y       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_HEADING = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_DRIVE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DIST_TOL       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_TOL      = 3'd5;

  // atan(2^-i) as a 32-bit binary angle
  localparam logic [31:0] ATAN_TAB [ATAN_ENTRIES] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic signed [18:0] target_x;
    logic signed [18:0] target_y;
    logic        [15:0] target_heading;
    logic               reverse_drive;
    logic        [15:0] distance_tolerance;
    logic        [14:0] angle_tolerance;
  } pet_cfg_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic        [31:0] z;
  } pet_vec_t;

  typedef struct packed {
    logic        zero;
    logic        moving;
    logic [15:0] heading;
    logic [15:0] ferr;
  } pet_side_t;

endpackage
`default_nettype wire

[src/pet_prep.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pet_prep
// Forms the vector to the target, folds it into the right half plane and
// registers the heading error.
// ----------------------------------------------------------------------------
module pet_prep (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               adv,
  input  wire logic               in_valid,
  input  wire pet_pkg::pet_cfg_t  cfg,
  input  wire logic signed [18:0] pose_x,
  input  wire logic signed [18:0] pose_y,
  input  wire logic        [15:0] pose_heading,
  input  wire logic               moving,
  output logic                    valid_o,
  output pet_pkg::pet_vec_t       vec_o,
  output pet_pkg::pet_side_t      side_o
);
  import pet_pkg::*;

  logic signed [19:0] dx;
  logic signed [19:0] dy;
  logic signed [31:0] x0;
  logic signed [31:0] y0;
  logic               valid_r;
  pet_vec_t           vec_r, vec_nxt;
  pet_side_t          side_r, side_nxt;

  always_comb begin
    dx = {cfg.target_x[18], cfg.target_x} - {pose_x[18], pose_x};
    dy = {cfg.target_y[18], cfg.target_y} - {pose_y[18], pose_y};
    x0 = {{4{dx[19]}}, dx, 8'h00};
    y0 = {{4{dy[19]}}, dy, 8'h00};
    // left half plane: rotate by pi first
    if (dx[19]) begin
      vec_nxt.x = -x0;
      vec_nxt.y = -y0;
      vec_nxt.z = 32'h80000000;
    end else begin
      vec_nxt.x = x0;
      vec_nxt.y = y0;
      vec_nxt.z = 32'h0;
    end
    side_nxt.zero    = (dx == 20'sd0) && (dy == 20'sd0);
    side_nxt.moving  = moving;
    side_nxt.heading = pose_heading;
    side_nxt.ferr    = cfg.target_heading - pose_heading;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      vec_r  <= vec_nxt;
      side_r <= side_nxt;
    end
  end

  assign valid_o = valid_r;
  assign vec_o   = vec_r;
  assign side_o  = side_r;

endmodule
`default_nettype wire

[src/pet_cordic_stage.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pet_cordic_stage
// One registered micro-rotation of the vectoring CORDIC.
// ----------------------------------------------------------------------------
module pet_cordic_stage #(
  parameter int STAGE = 0
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               adv,
  input  wire logic               valid_i,
  input  wire pet_pkg::pet_vec_t  vec_i,
  input  wire pet_pkg::pet_side_t side_i,
  output logic                    valid_o,
  output pet_pkg::pet_vec_t       vec_o,
  output pet_pkg::pet_side_t      side_o
);
  import pet_pkg::*;

  logic signed [31:0] xs;
  logic signed [31:0] ys;
  logic               valid_r;
  pet_vec_t           vec_r, vec_nxt;
  pet_side_t          side_r;

  always_comb begin
    xs = vec_i.x >>> STAGE;
    ys = vec_i.y >>> STAGE;
    // drive y towards zero
    if (!vec_i.y[31]) begin
      vec_nxt.x = vec_i.x + ys;
      vec_nxt.y = vec_i.y - xs;
      vec_nxt.z = vec_i.z + ATAN_TAB[STAGE];
    end else begin
      vec_nxt.x = vec_i.x - ys;
      vec_nxt.y = vec_i.y + xs;
      vec_nxt.z = vec_i.z - ATAN_TAB[STAGE];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      vec_r  <= vec_nxt;
      side_r <= side_i;
    end
  end

  assign valid_o = valid_r;
  assign vec_o   = vec_r;
  assign side_o  = side_r;

endmodule
`default_nettype wire

[src/pet_finish.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pet_finish
// Gain correction multiply, then saturation, angle wrap and arrival test into
// the output register.
// ----------------------------------------------------------------------------
module pet_finish #(
  parameter int STAGES = pet_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               adv,
  input  wire pet_pkg::pet_cfg_t  cfg,
  input  wire logic               valid_i,
  input  wire pet_pkg::pet_vec_t  vec_i,
  input  wire pet_pkg::pet_side_t side_i,
  output logic                    out_valid,
  output logic signed [19:0]      out_signed_distance,
  output logic        [15:0]      out_bearing_error,
  output logic        [15:0]      out_final_angle_error,
  output logic                    out_arrived
);
  import pet_pkg::*;

  // inverse CORDIC gain in Q32, trimmed for the stage count
  localparam logic [63:0] GAIN_FULL =
    64'h9B74EDA8 + (((64'h9B74EDA8 * 2) / 3) >> (2 * STAGES));
  localparam logic [31:0] GAIN = GAIN_FULL[31:0];
  localparam logic [63:0] ROUND_HALF = 64'h0000_0080_0000_0000;

  logic [30:0] x_clamp;
  logic [62:0] prod_nxt;
  logic        valid_a_r;
  logic [62:0] prod_a_r;
  logic [31:0] z_a_r;
  pet_side_t   side_a_r;

  logic [63:0] sum;
  logic [23:0] mag;
  logic [19:0] sat;
  logic [31:0] ang;
  logic [31:0] ang_rnd;
  logic [16:0] fabs;

  logic               valid_r;
  logic signed [19:0] dist_r, dist_nxt;
  logic        [15:0] berr_r, berr_nxt;
  logic        [15:0] ferr_r;
  logic               arr_r, arr_nxt;

  always_comb begin
    x_clamp  = vec_i.x[31] ? 31'd0 : vec_i.x[30:0];
    prod_nxt = 63'(x_clamp) * 63'(GAIN);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_a_r <= 1'b0;
      valid_r   <= 1'b0;
    end else if (adv) begin
      valid_a_r <= valid_i;
      valid_r   <= valid_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_a_r <= prod_nxt;
      z_a_r    <= vec_i.z;
      side_a_r <= side_i;
    end
  end

  always_comb begin
    sum      = {1'b0, prod_a_r} + ROUND_HALF;
    mag      = sum[63:40];
    sat      = (mag > 24'(DIST_MAX)) ? 20'(DIST_MAX) : mag[19:0];
    dist_nxt = cfg.reverse_drive ? -$signed(sat) : $signed(sat);
    // a zero vector has no direction: call it zero
    ang      = side_a_r.zero ? 32'h0 : z_a_r;
    if (cfg.reverse_drive) begin
      ang = ang + 32'h80000000;
    end
    ang_rnd  = ang + 32'h00008000;
    berr_nxt = ang_rnd[31:16] - side_a_r.heading;
    fabs     = side_a_r.ferr[15] ? (17'h10000 - {1'b0, side_a_r.ferr})
                                 : {1'b0, side_a_r.ferr};
    arr_nxt  = (mag < {8'd0, cfg.distance_tolerance}) &&
               (fabs < {2'b00, cfg.angle_tolerance}) && !side_a_r.moving;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dist_r <= dist_nxt;
      berr_r <= berr_nxt;
      ferr_r <= side_a_r.ferr;
      arr_r  <= arr_nxt;
    end
  end

  assign out_valid             = valid_r;
  assign out_signed_distance   = dist_r;
  assign out_bearing_error     = berr_r;
  assign out_final_angle_error = ferr_r;
  assign out_arrived           = arr_r;

endmodule
`default_nettype wire

[src/pose_error_to_target.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pose_error_to_target
// Distance, bearing error, final heading error and arrival flag of a measured
// pose against a configured target pose, by a pipelined vectoring CORDIC.
// ----------------------------------------------------------------------------
//  channel   direction  handshake               payload
//  in_       input      in_valid / in_ready     pose_x, pose_y, pose_heading, moving
//  out_      output     out_valid / out_ready   signed_distance, bearing_error,
//                                               final_angle_error, arrived
//  cfg_      input      cfg_we                  cfg_index, cfg_data
//
//  One beat in and one beat out per cycle while the output is not stalled.
//  The pipe holds a prep register, one register per CORDIC rotation, the
//  gain multiply register and the output register.
//  Synchronous active-low reset empties the pipe and loads the default
//  registers. A stalled output beat freezes the whole pipe; nothing is lost.
// ----------------------------------------------------------------------------
module pose_error_to_target #(
  parameter int CORDIC_STAGES = pet_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic signed [18:0]             in_pose_x,
  input  wire logic signed [18:0]             in_pose_y,
  input  wire logic signed [15:0]             in_pose_heading,
  input  wire logic                           in_moving,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic signed [19:0]                  out_signed_distance,
  output logic signed [15:0]                  out_bearing_error,
  output logic signed [15:0]                  out_final_angle_error,
  output logic                                out_arrived,
  input  wire logic                           cfg_we,
  input  wire logic [pet_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pet_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pet_pkg::*;

  localparam int NS = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;

  pet_cfg_t   cfg_r;
  logic       adv;
  logic       valid_q [NS+1];
  pet_vec_t   vec_q   [NS+1];
  pet_side_t  side_q  [NS+1];
  logic [15:0] berr_u;
  logic [15:0] ferr_u;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_x           <= '0;
      cfg_r.target_y           <= '0;
      cfg_r.target_heading     <= '0;
      cfg_r.reverse_drive      <= 1'b0;
      cfg_r.distance_tolerance <= 16'd16;
      cfg_r.angle_tolerance    <= 15'd64;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TARGET_X:       cfg_r.target_x           <= cfg_data;
        CFG_TARGET_Y:       cfg_r.target_y           <= cfg_data;
        CFG_TARGET_HEADING: cfg_r.target_heading     <= cfg_data[15:0];
        CFG_REVERSE_DRIVE:  cfg_r.reverse_drive      <= cfg_data[0];
        CFG_DIST_TOL:       cfg_r.distance_tolerance <= cfg_data[15:0];
        CFG_ANGLE_TOL:      cfg_r.angle_tolerance    <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // advance everything unless the output beat is held
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  pet_prep u_prep (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv),
    .in_valid     (in_valid),
    .cfg          (cfg_r),
    .pose_x       (in_pose_x),
    .pose_y       (in_pose_y),
    .pose_heading (in_pose_heading),
    .moving       (in_moving),
    .valid_o      (valid_q[0]),
    .vec_o        (vec_q[0]),
    .side_o       (side_q[0])
  );

  for (genvar g = 0; g < NS; g++) begin : g_rot
    pet_cordic_stage #(.STAGE(g)) u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .valid_i (valid_q[g]),
      .vec_i   (vec_q[g]),
      .side_i  (side_q[g]),
      .valid_o (valid_q[g+1]),
      .vec_o   (vec_q[g+1]),
      .side_o  (side_q[g+1])
    );
  end

  pet_finish #(.STAGES(NS)) u_finish (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .adv                   (adv),
    .cfg                   (cfg_r),
    .valid_i               (valid_q[NS]),
    .vec_i                 (vec_q[NS]),
    .side_i                (side_q[NS]),
    .out_valid             (out_valid),
    .out_signed_distance   (out_signed_distance),
    .out_bearing_error     (berr_u),
    .out_final_angle_error (ferr_u),
    .out_arrived           (out_arrived)
  );

  assign out_bearing_error     = $signed(berr_u);
  assign out_final_angle_error = $signed(ferr_u);

  // a held output beat must freeze the input side too
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while output stalled");

  // saturation never yields the most negative code
  a_dist_symmetric: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_signed_distance != 20'sh80000)
    else $error("distance outside saturated range");

  // a half-turn heading error can never count as arrival
  a_arrive_heading: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_arrived |-> out_final_angle_error != 16'sh8000)
    else $error("arrival flagged at half-turn heading error");

  // the last rotation stage only fills while the pipe advances
  a_pipe_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(valid_q[NS]))
    else $error("pipeline moved during stall");

endmodule
`default_nettype wire

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for pose_error_to_target. Pose beats go in through a
// queue-fed driver. A bit-true CORDIC predictor works out the distance,
// bearing error, heading error and arrival flag of every accepted beat. A
// monitor compares each result beat with the oldest prediction. The target
// registers move between phases, and both sides stall at random.
// ----------------------------------------------------------------------------
module tb;
  import pet_pkg::*;

  localparam int STAGES       = 16;
  localparam int LAT          = STAGES + 3;
  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLDOFF_LEN  = 300;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic signed [18:0] x;
    logic signed [18:0] y;
    logic        [15:0] heading;
    logic               moving;
  } pose_t;

  typedef struct packed {
    logic signed [19:0] distance;
    logic signed [15:0] bearing;
    logic signed [15:0] final_err;
    logic               arrived;
  } pose_err_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic signed [18:0]          in_pose_x = '0;
  logic signed [18:0]          in_pose_y = '0;
  logic signed [15:0]          in_pose_heading = '0;
  logic                        in_moving = 1'b0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic signed [19:0]          out_signed_distance;
  logic signed [15:0]          out_bearing_error;
  logic signed [15:0]          out_final_angle_error;
  logic                        out_arrived;
  logic                        cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]        cfg_index = '0;
  logic [CFG_DATA_W-1:0]       cfg_data = '0;

  // register shadow, reset values
  logic signed [18:0] tgt_x = '0;
  logic signed [18:0] tgt_y = '0;
  logic        [15:0] tgt_hd = '0;
  logic               rev = 1'b0;
  logic        [15:0] dtol = 16'd16;
  logic        [14:0] atol = 15'd64;

  pose_t     pose_queue[$];
  pose_err_t due_errors[$];
  bit        in_beat;
  bit        idle_en = 1'b1;
  bit        holdoff_req;
  int        in_gap;
  int        out_gap;
  int        rx_hold_left;
  int        fails;
  int        cycle_count;

  pose_error_to_target #(.CORDIC_STAGES(STAGES)) DUT (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_pose_x             (in_pose_x),
    .in_pose_y             (in_pose_y),
    .in_pose_heading       (in_pose_heading),
    .in_moving             (in_moving),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_signed_distance   (out_signed_distance),
    .out_bearing_error     (out_bearing_error),
    .out_final_angle_error (out_final_angle_error),
    .out_arrived           (out_arrived),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data)
  );

  always #1 clk = ~clk;

  // atan(2^-i) as a 32-bit binary angle
  function automatic logic [31:0] atan_step(int i);
    case (i)
      0:  return 32'h20000000;
      1:  return 32'h12E4051E;
      2:  return 32'h09FB385B;
      3:  return 32'h051111D4;
      4:  return 32'h028B0D43;
      5:  return 32'h0145D7E1;
      6:  return 32'h00A2F61E;
      7:  return 32'h00517C55;
      8:  return 32'h0028BE53;
      9:  return 32'h00145F2F;
      10: return 32'h000A2F98;
      11: return 32'h000517CC;
      12: return 32'h00028BE6;
      13: return 32'h000145F3;
      14: return 32'h0000A2FA;
      15: return 32'h0000517D;
      16: return 32'h000028BE;
      17: return 32'h0000145F;
      18: return 32'h00000A30;
      19: return 32'h00000518;
      20: return 32'h0000028C;
      21: return 32'h00000146;
      22: return 32'h000000A3;
      default: return 32'h00000051;
    endcase
  endfunction

  function automatic pose_err_t pose_error_of(pose_t p);
    longint            dx, dy, x, y, xs, ys, sdist;
    longint unsigned   gain, mag, xu;
    logic [31:0]       z, zr;
    logic [15:0]       ferr, fabs;
    int                n, i;
    pose_err_t         r;
    n = (STAGES > 24) ? 24 : STAGES;
    dx = longint'(tgt_x) - longint'(p.x);
    dy = longint'(tgt_y) - longint'(p.y);
    z = '0;
    mag = 0;
    if (dx != 0 || dy != 0) begin
      x = dx * 256;
      y = dy * 256;
      // fold the left half-plane over, starting the angle at pi
      if (x < 0) begin
        x = -x;
        y = -y;
        z = 32'h8000_0000;
      end
      for (i = 0; i < n; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys;
          y = y - xs;
          z = z + atan_step(i);
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - atan_step(i);
        end
      end
      gain = 64'h9B74EDA8 + ((64'h9B74EDA8 * 64'd2 / 64'd3) >> (2 * n));
      if (x < 0) x = 0;
      xu = x;
      mag = (xu * gain + (64'd1 << 39)) >> 40;
    end
    if (rev) z = z + 32'h8000_0000;
    zr = z + 32'h0000_8000;
    r.bearing = zr[31:16] - p.heading;
    ferr = tgt_hd - p.heading;
    r.final_err = ferr;
    fabs = ferr[15] ? (16'd0 - ferr) : ferr;
    sdist = (mag > DIST_MAX) ? DIST_MAX : longint'(mag);
    if (rev) sdist = -sdist;
    r.distance = sdist[19:0];
    r.arrived = (mag < dtol) && (fabs < atol) && !p.moving;
    return r;
  endfunction

  function automatic void add_pose(logic signed [18:0] x, logic signed [18:0] y,
                                   logic [15:0] h, logic m);
    pose_t p;
    p.x = x;
    p.y = y;
    p.heading = h;
    p.moving = m;
    pose_queue.push_back(p);
  endfunction

  function automatic pose_t random_pose();
    pose_t p;
    int    kind, off;
    kind = $urandom_range(0, 9);
    p.x = 19'($urandom);
    p.y = 19'($urandom);
    p.heading = 16'($urandom);
    p.moving = 1'($urandom_range(0, 1));
    if (kind < 4) begin
      // close to the target, where arrival can happen
      off = $urandom_range(0, 64);
      p.x = 19'(tgt_x + off - 32);
      off = $urandom_range(0, 64);
      p.y = 19'(tgt_y + off - 32);
      off = $urandom_range(0, 400);
      p.heading = 16'(tgt_hd + off - 200);
      p.moving = ($urandom_range(0, 3) == 0);
    end else if (kind == 8) begin
      p.x = $urandom_range(0, 1) ? 19'h3FFFF : 19'h40000;
      p.y = $urandom_range(0, 1) ? 19'h3FFFF : 19'h40000;
      case ($urandom_range(0, 3))
        0: p.heading = 16'h7FFF;
        1: p.heading = 16'h8000;
        2: p.heading = 16'h0000;
        default: p.heading = 16'hFFFF;
      endcase
    end else if (kind == 9) begin
      if ($urandom_range(0, 1)) p.x = tgt_x;
      else p.y = tgt_y;
    end
    return p;
  endfunction

  // write one register; bits above its width carry noise
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [18:0] value);
    logic [18:0] data;
    data = value;
    case (idx)
      CFG_TARGET_X:       tgt_x = data;
      CFG_TARGET_Y:       tgt_y = data;
      CFG_TARGET_HEADING: begin data[18:16] = 3'($urandom); tgt_hd = data[15:0]; end
      CFG_REVERSE_DRIVE:  begin data[18:1] = 18'($urandom); rev = data[0]; end
      CFG_DIST_TOL:       begin data[18:16] = 3'($urandom); dtol = data[15:0]; end
      CFG_ANGLE_TOL:      begin data[18:15] = 4'($urandom); atol = data[14:0]; end
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_random_setting();
    write_reg(CFG_TARGET_X, ($urandom_range(0, 4) == 0) ?
              ($urandom_range(0, 1) ? 19'h3FFFF : 19'h40000) : 19'($urandom));
    write_reg(CFG_TARGET_Y, ($urandom_range(0, 4) == 0) ?
              ($urandom_range(0, 1) ? 19'h3FFFF : 19'h40000) : 19'($urandom));
    write_reg(CFG_TARGET_HEADING, 19'($urandom));
    write_reg(CFG_REVERSE_DRIVE, 19'($urandom_range(0, 1)));
    case ($urandom_range(0, 4))
      0: write_reg(CFG_DIST_TOL, 19'd0);
      1: write_reg(CFG_DIST_TOL, 19'd65535);
      default: write_reg(CFG_DIST_TOL, 19'($urandom_range(0, 2000)));
    endcase
    case ($urandom_range(0, 4))
      0: write_reg(CFG_ANGLE_TOL, 19'd0);
      1: write_reg(CFG_ANGLE_TOL, 19'd32767);
      default: write_reg(CFG_ANGLE_TOL, 19'($urandom_range(0, 3000)));
    endcase
    if ($urandom_range(0, 2) == 0) write_reg(CFG_SPARE_HI, 19'($urandom));
  endtask

  // wait until every beat is in and every result is out, then let the pipe settle
  task automatic drain();
    while (pose_queue.size() != 0 || in_valid || due_errors.size() != 0)
      @(posedge clk);
    repeat (LAT + 2) @(posedge clk);
  endtask

  // input side: take note of accepted beats and predict their results
  always @(posedge clk) begin
    pose_t p;
    in_beat = rst_n && in_valid && in_ready;
    if (in_beat) begin
      p.x = in_pose_x;
      p.y = in_pose_y;
      p.heading = in_pose_heading;
      p.moving = in_moving;
      due_errors.push_back(pose_error_of(p));
    end
  end

  always @(negedge clk) begin
    pose_t p;
    if (in_valid && !in_beat) begin
      // hold the beat until it is taken
    end else if (in_gap != 0) begin
      in_valid <= 1'b0;
      in_gap--;
    end else if (pose_queue.size() != 0) begin
      if (idle_en && $urandom_range(0, 5) == 0) begin
        in_valid <= 1'b0;
        in_gap = $urandom_range(0, 12);
      end else begin
        p = pose_queue.pop_front();
        in_pose_x <= p.x;
        in_pose_y <= p.y;
        in_pose_heading <= p.heading;
        in_moving <= p.moving;
        in_valid <= 1'b1;
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // result side
  always @(negedge clk) begin
    if (holdoff_req) begin
      rx_hold_left = HOLDOFF_LEN;
      holdoff_req = 1'b0;
    end
    if (rx_hold_left != 0) begin
      out_ready <= 1'b0;
      rx_hold_left--;
    end else if (out_gap != 0) begin
      out_ready <= 1'b0;
      out_gap--;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      out_gap = $urandom_range(0, 12);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    pose_err_t want;
    if (rst_n && out_valid && out_ready) begin
      if (due_errors.size() == 0) begin
        $error("result beat with no pose pending");
        fails++;
      end else begin
        want = due_errors.pop_front();
        if (out_signed_distance !== want.distance) begin
          $error("signed_distance: expected %0d, got %0d", want.distance,
                 out_signed_distance);
          fails++;
        end
        if (out_bearing_error !== want.bearing) begin
          $error("bearing_error: expected %0d, got %0d", want.bearing, out_bearing_error);
          fails++;
        end
        if (out_final_angle_error !== want.final_err) begin
          $error("final_angle_error: expected %0d, got %0d", want.final_err,
                 out_final_angle_error);
          fails++;
        end
        if (out_arrived !== want.arrived) begin
          $error("arrived: expected %0b, got %0b", want.arrived, out_arrived);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("pose_error_to_target verification failed");
      $finish;
    end
  end

  initial begin
    int ph;
    int k;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset setting: target at the origin, tolerances 16 and 64
    add_pose(0, 0, 0, 0);             // zero vector, arrived
    add_pose(0, 0, 0, 1);             // still moving
    add_pose(0, 0, -32768, 0);        // heading error of -pi never within tolerance
    add_pose(0, 0, 63, 0);
    add_pose(0, 0, -64, 0);
    add_pose(15, 0, 0, 0);            // just inside the distance bound
    add_pose(0, -16, 0, 0);           // on the distance bound
    add_pose(1, 0, 0, 0);
    add_pose(-262144, -262144, 32767, 0);
    add_pose(262143, 262143, -1, 1);
    add_pose(-262144, 262143, 0, 0);
    add_pose(0, 262143, 16'h4000, 0);
    drain();

    write_reg(CFG_TARGET_X, 19'h3FFFF);
    write_reg(CFG_TARGET_Y, 19'h40000);
    write_reg(CFG_TARGET_HEADING, 19'h08000);
    write_reg(CFG_REVERSE_DRIVE, 19'd1);
    write_reg(CFG_DIST_TOL, 19'd65535);
    write_reg(CFG_ANGLE_TOL, 19'd32767);
    write_reg(CFG_SPARE_LO, 19'($urandom));
    add_pose(-262144, 262143, 0, 0);  // longest vector, distance saturates
    add_pose(262143, -262144, 0, 0);  // zero vector while reversing
    add_pose(262143, -262044, -32768, 0);
    add_pose(258143, -262144, 16'h7FFF, 0);
    add_pose(262143, -262144, -32767, 1);
    drain();

    write_reg(CFG_TARGET_X, 19'h40000);
    write_reg(CFG_TARGET_Y, 19'h3FFFF);
    write_reg(CFG_TARGET_HEADING, 19'h07FFF);
    write_reg(CFG_REVERSE_DRIVE, 19'd0);
    write_reg(CFG_DIST_TOL, 19'd0);
    write_reg(CFG_ANGLE_TOL, 19'd0);
    add_pose(262143, -262144, 0, 0);  // saturates from the left half-plane
    add_pose(-262144, 262143, 32767, 0);
    add_pose(262143, 262143, -32768, 0);
    add_pose(-262144, -262144, 1, 0);
    drain();

    for (ph = 0; ph < 8; ph++) begin
      load_random_setting();
      idle_en = (ph != 7) && ($urandom_range(0, 4) != 0);
      // let the pipe fill against a stalled receiver
      if (ph == 0) begin
        @(posedge clk);
        holdoff_req = 1'b1;
      end
      for (k = 0; k < 125; k++) pose_queue.push_back(random_pose());
      drain();
    end

    if (fails == 0) begin
      $display("pose_error_to_target verification clean");
    end else begin
      $display("pose_error_to_target verification failed");
    end
    $finish;
  end

endmodule

[files.f]
src/pet_pkg.sv
src/pet_prep.sv
src/pet_cordic_stage.sv
src/pet_finish.sv
src/pose_error_to_target.sv
tb/sv/tb.sv
